### hdl/fspl_pkg.sv
// Shared types and constants of the servo position loop.
package fspl_pkg;

    localparam int PERIOD_MIN_US = 1000;
    localparam int PERIOD_MAX_US = 1200;
    localparam int HOLD_RESET    = 1500;

    // Width of a valid period and of either of its parts.
    localparam int CYC_W   = $clog2(PERIOD_MAX_US);
    localparam int TIME_W  = 16;
    localparam int TGT_W   = 13;
    localparam int GAIN_W  = 8;
    localparam int MAXO_W  = 10;
    localparam int MINO_W  = 11;
    localparam int DEAD_W  = 8;
    localparam int PULSE_W = 12;
    localparam int DUTY_W  = 10;
    localparam int TURN_W  = 8;
    localparam int CFG_W   = 13;
    localparam int IDX_W   = 3;
    localparam int SPD_W   = 12;

    localparam int PULSE_MAX = (1 << PULSE_W) - 1;

    typedef enum logic [IDX_W-1:0] {
        REG_TARGET_ANGLE = 3'd0,
        REG_GAIN_KP      = 3'd1,
        REG_MAX_SPEED    = 3'd2,
        REG_MIN_SPEED    = 3'd3,
        REG_DEAD_OFFSET  = 3'd4,
        REG_HOLD_STILL   = 3'd5,
        REG_DUTY_LOW     = 3'd6,
        REG_DUTY_HIGH    = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [TIME_W-1:0] high_time;
        logic [TIME_W-1:0] low_time;
    } t_in;

    typedef struct packed {
        logic                     sample_ok;
        logic [PULSE_W-1:0]       pulse_width;
        logic [TGT_W-1:0]         angle_now;
        logic signed [TURN_W-1:0] turn_count;
    } t_out;

    typedef struct packed {
        logic [TGT_W-1:0]         target_angle;
        logic [GAIN_W-1:0]        gain_kp;
        logic [MAXO_W-1:0]        max_speed_offset;
        logic signed [MINO_W-1:0] min_speed_offset;
        logic [DEAD_W-1:0]        dead_offset;
        logic [PULSE_W-1:0]       hold_still_us;
        logic [DUTY_W-1:0]        duty_low;
        logic [DUTY_W-1:0]        duty_high;
    } t_cfg;

    // Sequencer commands to the datapath.
    typedef struct packed {
        logic load;
        logic prod;
        logic scale;
        logic div_init;
        logic div_step;
        logic angle;
        logic mult;
        logic pulse;
        logic out_load;
    } t_cmd;

    // Datapath status back to the sequencer.
    typedef struct packed {
        logic sample_valid;
        logic seeded;
    } t_sts;

endpackage

### hdl/feedback_servo_position_loop_unit.sv
// Top level of the servo position loop: configuration, sequencer and datapath.
//
// Input channel (i_in_valid / o_in_stall / i_in_data) carries one measured
// feedback period per transfer: high time and low time in microseconds.
// Output channel (o_out_valid / i_out_stall / o_out_data) returns exactly one
// result per input transfer: sample_ok, commanded pulse, angle, turn count.
// Configuration is written through i_cfg_we / i_cfg_index / i_cfg_wdata; the
// user must write it only while the block is idle, which the block itself
// does not enforce. A write takes effect at the next clock edge.
// Per sample, the transfer edge loads the period; S_PROD forms the products
// and sends a rejected period straight to S_OUT; S_SCALE, S_CHECK and the
// S_DIV steps form the angle; a seeding sample goes from S_ANGLE to S_OUT,
// a regular one on through S_MULT and S_PULSE. S_OUT loads the result
// register, and the result is valid right after the edge that loads it.
// The restoring divider in the datapath makes one quotient bit per cycle; the
// block works on one sample at a time and accepts the next transfer as soon
// as it returns to idle, even while the previous result still waits in the
// output register.
// When the receiver stalls, the result holds in the output register and a
// finished next sample waits in its last step until that register frees.
// Reset (synchronous, active low) restores the register defaults, clears
// the turn counter and the seeded flag, and sets the last pulse to 1500 us.
module feedback_servo_position_loop_unit #(
    parameter int DUTY_FULL_SCALE    = 1000,
    parameter int UNITS_PER_CIRCLE   = 360,
    parameter int QUADRANT_TWO_START = 90,
    parameter int QUADRANT_THREE_END = 270
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  fspl_pkg::t_in                 i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output fspl_pkg::t_out                o_out_data,
    input  logic                          i_cfg_we,
    input  logic [fspl_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [fspl_pkg::CFG_W-1:0]    i_cfg_wdata
);

    // Quotient width of the angle divide equals the full-scale angle width.
    localparam int FULL_ANGLE = (UNITS_PER_CIRCLE - 1) * 16;
    localparam int DIV_STEPS  = $clog2(FULL_ANGLE + 1);

    fspl_pkg::t_cfg cfg;
    fspl_pkg::t_cmd cmd;
    fspl_pkg::t_sts sts;

    // Hold the register file; writes land at the next edge.
    fspl_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Advance one sample through capture, divide, angle, gain and pulse steps.
    fspl_ctrl #(
        .DIV_STEPS (DIV_STEPS)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Compute the angle, count turns and form the pulse under sequencer control.
    fspl_dp #(
        .DUTY_FULL_SCALE    (DUTY_FULL_SCALE),
        .UNITS_PER_CIRCLE   (UNITS_PER_CIRCLE),
        .QUADRANT_TWO_START (QUADRANT_TWO_START),
        .QUADRANT_THREE_END (QUADRANT_THREE_END)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

### hdl/fspl_cfg.sv
// Configuration register file of the servo position loop.
module fspl_cfg (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [fspl_pkg::IDX_W-1:0]    i_cfg_index,
    input  logic [fspl_pkg::CFG_W-1:0]    i_cfg_wdata,
    output fspl_pkg::t_cfg                o_cfg
);

    fspl_pkg::t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.target_angle     <= '0;
            r_cfg.gain_kp          <= fspl_pkg::GAIN_W'(16);
            r_cfg.max_speed_offset <= fspl_pkg::MAXO_W'(200);
            r_cfg.min_speed_offset <= -fspl_pkg::MINO_W'(200);
            r_cfg.dead_offset      <= fspl_pkg::DEAD_W'(30);
            r_cfg.hold_still_us    <= fspl_pkg::PULSE_W'(fspl_pkg::HOLD_RESET);
            r_cfg.duty_low         <= fspl_pkg::DUTY_W'(29);
            r_cfg.duty_high        <= fspl_pkg::DUTY_W'(971);
        end else if (i_cfg_we) begin
            case (fspl_pkg::t_reg_idx'(i_cfg_index))
                fspl_pkg::REG_TARGET_ANGLE: begin
                    r_cfg.target_angle <= i_cfg_wdata[fspl_pkg::TGT_W-1:0];
                end
                fspl_pkg::REG_GAIN_KP: begin
                    r_cfg.gain_kp <= i_cfg_wdata[fspl_pkg::GAIN_W-1:0];
                end
                fspl_pkg::REG_MAX_SPEED: begin
                    r_cfg.max_speed_offset <= i_cfg_wdata[fspl_pkg::MAXO_W-1:0];
                end
                fspl_pkg::REG_MIN_SPEED: begin
                    r_cfg.min_speed_offset <= $signed(i_cfg_wdata[fspl_pkg::MINO_W-1:0]);
                end
                fspl_pkg::REG_DEAD_OFFSET: begin
                    r_cfg.dead_offset <= i_cfg_wdata[fspl_pkg::DEAD_W-1:0];
                end
                fspl_pkg::REG_HOLD_STILL: begin
                    r_cfg.hold_still_us <= i_cfg_wdata[fspl_pkg::PULSE_W-1:0];
                end
                fspl_pkg::REG_DUTY_LOW: begin
                    r_cfg.duty_low <= i_cfg_wdata[fspl_pkg::DUTY_W-1:0];
                end
                fspl_pkg::REG_DUTY_HIGH: begin
                    r_cfg.duty_high <= i_cfg_wdata[fspl_pkg::DUTY_W-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hdl/fspl_ctrl.sv
// Sequencer of the servo position loop: steps one sample through the datapath.
module fspl_ctrl #(
    parameter int DIV_STEPS = 13
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    input  fspl_pkg::t_sts i_sts,
    output fspl_pkg::t_cmd o_cmd
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PROD  = 9'b000000010,
        S_SCALE = 9'b000000100,
        S_CHECK = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_ANGLE = 9'b000100000,
        S_MULT  = 9'b001000000,
        S_PULSE = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state             r_state, n_state;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic               r_out_valid, n_out_valid;
    logic               slot_free;

    assign slot_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != S_IDLE);

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_out_stall;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_PROD;
                end
            end
            S_PROD: begin
                o_cmd.prod = 1'b1;
                n_state    = i_sts.sample_valid ? S_SCALE : S_OUT;
            end
            S_SCALE: begin
                o_cmd.scale = 1'b1;
                n_state     = S_CHECK;
            end
            S_CHECK: begin
                o_cmd.div_init = 1'b1;
                n_cnt          = CNT_W'(DIV_STEPS - 1);
                n_state        = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - CNT_W'(1);
                if (r_cnt == '0) begin
                    n_state = S_ANGLE;
                end
            end
            S_ANGLE: begin
                o_cmd.angle = 1'b1;
                n_state     = i_sts.seeded ? S_MULT : S_OUT;
            end
            S_MULT: begin
                o_cmd.mult = 1'b1;
                n_state    = S_PULSE;
            end
            S_PULSE: begin
                o_cmd.pulse = 1'b1;
                n_state     = S_OUT;
            end
            S_OUT: begin
                if (slot_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("sequencer accepted a transfer without going busy");

    a_result_after_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (o_out_valid && !o_in_stall))
        else $error("result load did not present a result and free the input");

endmodule

### hdl/fspl_dp.sv
// Datapath of the servo position loop: angle, divider, turn counter, pulse.
module fspl_dp #(
    parameter int DUTY_FULL_SCALE    = 1000,
    parameter int UNITS_PER_CIRCLE   = 360,
    parameter int QUADRANT_TWO_START = 90,
    parameter int QUADRANT_THREE_END = 270
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  fspl_pkg::t_cfg i_cfg,
    input  fspl_pkg::t_in  i_in_data,
    input  fspl_pkg::t_cmd i_cmd,
    output fspl_pkg::t_sts o_sts,
    output fspl_pkg::t_out o_out_data
);

    localparam int CYC_W   = fspl_pkg::CYC_W;
    localparam int TIME_W  = fspl_pkg::TIME_W;
    localparam int TGT_W   = fspl_pkg::TGT_W;
    localparam int DUTY_W  = fspl_pkg::DUTY_W;
    localparam int TURN_W  = fspl_pkg::TURN_W;
    localparam int PULSE_W = fspl_pkg::PULSE_W;
    localparam int SPD_W   = fspl_pkg::SPD_W;

    localparam int FULL_ANGLE = (UNITS_PER_CIRCLE - 1) * 16;
    localparam int ANG_W      = $clog2(FULL_ANGLE + 1);
    localparam int DFS_W      = $clog2(DUTY_FULL_SCALE + 1);
    localparam int P1_W       = DFS_W + CYC_W;
    localparam int P2_W       = DUTY_W + CYC_W;
    localparam int D_W        = ((P1_W > P2_W) ? P1_W : P2_W) + 1;
    localparam int MAG_W      = D_W - 1;
    localparam int UNITS16    = UNITS_PER_CIRCLE * 16;
    localparam int U16_W      = $clog2(UNITS16 + 1);
    localparam int N_W        = MAG_W + U16_W;
    localparam int SPAN_W     = DUTY_W + 2;
    localparam int SMAG_W     = DUTY_W + 1;
    localparam int DEN_W      = CYC_W + SMAG_W;
    localparam int HP_W       = N_W - ANG_W;
    localparam int CMPD_W     = (HP_W > DEN_W) ? HP_W : DEN_W;
    localparam int Q2_ANGLE   = QUADRANT_TWO_START * 16;
    localparam int Q3_ANGLE   = QUADRANT_THREE_END * 16;
    localparam int Q2_W       = $clog2(Q2_ANGLE + 1);
    localparam int Q3_W       = $clog2(Q3_ANGLE + 1);
    localparam int QM_W       = (Q2_W > Q3_W) ? Q2_W : Q3_W;
    localparam int CMP_W      = (QM_W > ANG_W) ? QM_W : ANG_W;
    localparam int ERR_W      = ((TGT_W > ANG_W) ? TGT_W : ANG_W) + 1;
    localparam int PR_W       = ERR_W + fspl_pkg::GAIN_W + 1;
    localparam int SD_W       = SPD_W + 1;
    localparam int PUL_W      = SD_W + 2;
    localparam int EXT_W      = (ANG_W > TGT_W) ? ANG_W : TGT_W;

    localparam logic signed [TURN_W-1:0] TURN_MAX = {1'b0, {(TURN_W-1){1'b1}}};
    localparam logic signed [TURN_W-1:0] TURN_MIN = {1'b1, {(TURN_W-1){1'b0}}};

    // Sample capture.
    logic [TIME_W-1:0]        r_hi, r_lo;
    logic                     r_valid, r_ok;
    logic [TIME_W:0]          in_cycle;

    // Numerator and denominator build.
    logic [P1_W-1:0]          r_p1;
    logic [P2_W-1:0]          r_p2;
    logic [DEN_W-1:0]         r_den;
    logic                     r_sd, r_sn;
    logic [N_W-1:0]           r_num;

    // Divider.
    logic [DEN_W-1:0]         r_rem;
    logic [ANG_W-1:0]         r_qsh;
    logic                     r_sat;

    // Loop state.
    logic [ANG_W-1:0]         r_prev, r_cur;
    logic                     r_seeded;
    logic signed [TURN_W-1:0] r_turns;
    logic [PULSE_W-1:0]       r_last;
    logic signed [ERR_W-1:0]  r_err;
    logic signed [PR_W-1:0]   r_prod;
    fspl_pkg::t_out           r_out;

    // Combinational terms.
    logic [CYC_W-1:0]         cyc;
    logic signed [SPAN_W-1:0] span_raw, span_s;
    logic [SMAG_W-1:0]        span_mag;
    logic signed [D_W-1:0]    diff;
    logic [MAG_W-1:0]         mag;
    logic [HP_W-1:0]          num_hp;
    logic [DEN_W:0]           trial, trial_sub;
    logic                     trial_ge;
    logic [ANG_W-1:0]         ang;
    logic [CMP_W-1:0]         ang_c, prev_c;
    logic                     wrap_up, wrap_down;
    logic [PR_W-1:0]          bias;
    logic signed [PR_W-1:0]   adj, sp_raw, max_s, min_s, sp_clamp;
    logic signed [SPD_W-1:0]  spd_c;
    logic signed [SD_W-1:0]   spd_d, spd_abs, spd_f;
    logic signed [PUL_W-1:0]  pulse_s;
    logic [PULSE_W-1:0]       pulse_sat;
    logic [EXT_W-1:0]         ang_ext;

    assign in_cycle = {1'b0, i_in_data.high_time} + {1'b0, i_in_data.low_time};

    // A valid period stays below PERIOD_MAX_US, so the narrow sum is exact.
    assign cyc = CYC_W'(r_hi + r_lo);

    always_comb begin
        span_raw = $signed({2'b00, i_cfg.duty_high}) - $signed({2'b00, i_cfg.duty_low})
                   + $signed(SPAN_W'(1));
        span_s   = (span_raw == '0) ? $signed(SPAN_W'(1)) : span_raw;
        span_mag = span_s[SPAN_W-1] ? SMAG_W'(-span_s) : SMAG_W'(span_s);
    end

    always_comb begin
        diff = $signed(D_W'(r_p1)) - $signed(D_W'(r_p2));
        mag  = diff[D_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
    end

    assign num_hp    = r_num[N_W-1:ANG_W];
    assign trial     = {r_rem, r_qsh[ANG_W-1]};
    assign trial_ge  = (trial >= {1'b0, r_den});
    assign trial_sub = trial - {1'b0, r_den};

    // Opposite signs give a negative quotient: the angle clips to full scale.
    always_comb begin
        if (r_sn != r_sd) begin
            ang = ANG_W'(FULL_ANGLE);
        end else if (r_sat || (r_qsh > ANG_W'(FULL_ANGLE))) begin
            ang = '0;
        end else begin
            ang = ANG_W'(FULL_ANGLE) - r_qsh;
        end
    end

    assign ang_c     = CMP_W'(ang);
    assign prev_c    = CMP_W'(r_prev);
    assign wrap_up   = (ang_c < CMP_W'(Q2_ANGLE)) && (prev_c > CMP_W'(Q3_ANGLE));
    assign wrap_down = (prev_c < CMP_W'(Q2_ANGLE)) && (ang_c > CMP_W'(Q3_ANGLE));

    // Round the scaled error toward zero, clamp, add the dead offset, steer, then add the hold pulse and saturate.
    always_comb begin
        bias   = {{(PR_W-8){1'b0}}, {8{r_prod[PR_W-1]}}};
        adj    = r_prod + $signed(bias);
        sp_raw = adj >>> 8;
        max_s  = $signed(PR_W'(i_cfg.max_speed_offset));
        min_s  = PR_W'(i_cfg.min_speed_offset);
        if (sp_raw > max_s) begin
            sp_clamp = max_s;
        end else if (sp_raw < min_s) begin
            sp_clamp = min_s;
        end else begin
            sp_clamp = sp_raw;
        end
        spd_c = SPD_W'(sp_clamp);
        if (r_err > 0) begin
            spd_d = SD_W'(spd_c) + $signed(SD_W'(i_cfg.dead_offset));
        end else if (r_err < 0) begin
            spd_d = SD_W'(spd_c) - $signed(SD_W'(i_cfg.dead_offset));
        end else begin
            spd_d = SD_W'(spd_c);
        end
        spd_abs = spd_d[SD_W-1] ? -spd_d : spd_d;
        if (r_turns > 0) begin
            spd_f = -spd_abs;
        end else if (r_turns < 0) begin
            spd_f = spd_abs;
        end else begin
            spd_f = spd_d;
        end
        pulse_s = $signed(PUL_W'(i_cfg.hold_still_us)) + PUL_W'(spd_f);
        if (pulse_s < 0) begin
            pulse_sat = '0;
        end else if (pulse_s > $signed(PUL_W'(fspl_pkg::PULSE_MAX))) begin
            pulse_sat = PULSE_W'(fspl_pkg::PULSE_MAX);
        end else begin
            pulse_sat = PULSE_W'(pulse_s);
        end
    end

    assign ang_ext = EXT_W'(r_cur);

    // Payload and arithmetic registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_hi    <= i_in_data.high_time;
            r_lo    <= i_in_data.low_time;
            r_valid <= (in_cycle > (TIME_W+1)'(fspl_pkg::PERIOD_MIN_US))
                    && (in_cycle < (TIME_W+1)'(fspl_pkg::PERIOD_MAX_US))
                    && (i_in_data.high_time != '0) && (i_in_data.low_time != '0);
        end
        if (i_cmd.prod) begin
            r_p1  <= P1_W'(DUTY_FULL_SCALE) * P1_W'(r_hi[CYC_W-1:0]);
            r_p2  <= P2_W'(i_cfg.duty_low) * P2_W'(cyc);
            r_den <= DEN_W'(cyc) * DEN_W'(span_mag);
            r_sd  <= span_s[SPAN_W-1];
            r_ok  <= r_valid;
        end
        if (i_cmd.scale) begin
            r_num <= N_W'(mag) * N_W'(UNITS16);
            r_sn  <= diff[D_W-1];
        end
        if (i_cmd.div_init) begin
            r_sat <= (CMPD_W'(num_hp) >= CMPD_W'(r_den));
            r_rem <= DEN_W'(num_hp);
            r_qsh <= r_num[ANG_W-1:0];
        end
        if (i_cmd.div_step) begin
            r_rem <= trial_ge ? DEN_W'(trial_sub) : DEN_W'(trial);
            r_qsh <= {r_qsh[ANG_W-2:0], trial_ge};
        end
        if (i_cmd.angle) begin
            r_err <= $signed(ERR_W'(i_cfg.target_angle)) - $signed(ERR_W'(ang));
        end
        if (i_cmd.mult) begin
            r_prod <= r_err * $signed({1'b0, i_cfg.gain_kp});
        end
        if (i_cmd.out_load) begin
            r_out.sample_ok   <= r_ok;
            r_out.pulse_width <= r_last;
            r_out.angle_now   <= ang_ext[TGT_W-1:0];
            r_out.turn_count  <= r_turns;
        end
    end

    // Loop state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev   <= '0;
            r_cur    <= '0;
            r_seeded <= 1'b0;
            r_turns  <= '0;
            r_last   <= PULSE_W'(fspl_pkg::HOLD_RESET);
        end else begin
            if (i_cmd.angle) begin
                r_prev   <= ang;
                r_cur    <= ang;
                r_seeded <= 1'b1;
                if (r_seeded) begin
                    if (wrap_up) begin
                        if (r_turns != TURN_MAX) begin
                            r_turns <= r_turns + TURN_W'(1);
                        end
                    end else if (wrap_down) begin
                        if (r_turns != TURN_MIN) begin
                            r_turns <= r_turns - TURN_W'(1);
                        end
                    end
                end
            end
            if (i_cmd.pulse) begin
                r_last <= pulse_sat;
            end
        end
    end

    assign o_sts.sample_valid = r_valid;
    assign o_sts.seeded       = r_seeded;
    assign o_out_data         = r_out;

    a_angle_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cur <= ANG_W'(FULL_ANGLE))
        else $error("current angle beyond full scale");

    a_turn_single_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_turns == $past(r_turns)
                         || r_turns == $past(r_turns) + TURN_W'(1)
                         || r_turns == $past(r_turns) - TURN_W'(1)))
        else $error("turn counter moved by more than one");

    a_angle_only_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.angle |-> (r_ok && r_valid))
        else $error("angle update on a rejected period");

endmodule

### bench/feedback_servo_position_loop_unit_test.sv
// Self-checking bench for the servo position loop: random periods, gaps and stalls.
module feedback_servo_position_loop_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    // Block size under test; the bench builds the block with the same figures.
    localparam int DUTY_FULL_SCALE    = 1000;
    localparam int UNITS_PER_CIRCLE   = 360;
    localparam int QUADRANT_TWO_START = 90;
    localparam int QUADRANT_THREE_END = 270;

    localparam int FULL_ANGLE    = (UNITS_PER_CIRCLE - 1) * 16;
    localparam int DUTY_REG_MAX  = 1000;
    localparam int ITEMS_PER_SET = 103;
    localparam int MAX_SETS      = 9;
    // Leave a margin after the last result before touching registers.
    localparam int DRAIN_CYCLES  = 30;
    localparam int CYCLE_LIMIT   = 1_000_000;

    logic                           clk = 1'b0;
    logic                           rst_n = 1'b0;
    logic                           in_valid = 1'b0;
    logic                           in_stall;
    fspl_pkg::t_in                  in_data = '0;
    logic                           out_valid;
    logic                           out_stall = 1'b1;
    fspl_pkg::t_out                 out_data;
    logic                           cfg_we = 1'b0;
    logic [fspl_pkg::IDX_W-1:0]     cfg_index = '0;
    logic [fspl_pkg::CFG_W-1:0]     cfg_wdata = '0;

    feedback_servo_position_loop_unit #(
        .DUTY_FULL_SCALE   (DUTY_FULL_SCALE),
        .UNITS_PER_CIRCLE  (UNITS_PER_CIRCLE),
        .QUADRANT_TWO_START(QUADRANT_TWO_START),
        .QUADRANT_THREE_END(QUADRANT_THREE_END)
    ) uut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_we   (cfg_we),
        .i_cfg_index(cfg_index),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // ------------------------------------------------------------------
    // Shadow of the loop: register settings and the state that a valid
    // period moves. Starts from the reset values of the block.
    // ------------------------------------------------------------------
    fspl_pkg::t_cfg servo_cfg = '{
        target_angle:     '0,
        gain_kp:          8'd16,
        max_speed_offset: 10'd200,
        min_speed_offset: -11'sd200,
        dead_offset:      8'd30,
        hold_still_us:    fspl_pkg::PULSE_W'(fspl_pkg::HOLD_RESET),
        duty_low:         10'd29,
        duty_high:        10'd971
    };

    logic [fspl_pkg::TGT_W-1:0]         prev_angle = '0;
    logic [fspl_pkg::TGT_W-1:0]         cur_angle = '0;
    logic                               seeded = 1'b0;
    logic signed [fspl_pkg::TURN_W-1:0] turn_total = '0;
    logic [fspl_pkg::PULSE_W-1:0]       last_pulse = fspl_pkg::PULSE_W'(fspl_pkg::HOLD_RESET);

    fspl_pkg::t_in  pending_periods[$];   // periods not yet offered to the block
    fspl_pkg::t_out expected_results[$];  // one per accepted period, oldest first

    int  mismatches = 0;
    int  results_seen = 0;
    int  cycle_count = 0;
    int  gap_left = 0;
    int  stall_left = 0;
    int  hold_left = 0;
    bit  long_hold_done = 1'b0;
    bit  period_taken = 1'b0;
    bit  result_taken = 1'b0;
    int  spin_region = 2;       // 0: first quadrant, 1: middle, 2: fourth quadrant

    // Advance the shadow state by one measured period and return what the
    // block must report for it.
    function automatic fspl_pkg::t_out next_feedback_result(fspl_pkg::t_in p);
        longint         hi, lo, cycle, span, num, den, quot, ang;
        longint         err, spd, pulse, dl, dh;
        fspl_pkg::t_out r;
        hi = p.high_time;
        lo = p.low_time;
        cycle = hi + lo;
        r.sample_ok = 1'b0;
        if (cycle > fspl_pkg::PERIOD_MIN_US && cycle < fspl_pkg::PERIOD_MAX_US
            && hi != 0 && lo != 0) begin
            dl = servo_cfg.duty_low;
            dh = servo_cfg.duty_high;
            span = dh - dl + 1;
            if (span == 0)
                span = 1;
            num = (DUTY_FULL_SCALE * hi - dl * cycle) * UNITS_PER_CIRCLE * 16;
            den = cycle * span;
            // Round the quotient toward minus infinity, not toward zero.
            quot = num / den;
            if (num % den != 0 && ((num < 0) != (den < 0)))
                quot = quot - 1;
            ang = FULL_ANGLE - quot;
            if (ang < 0)
                ang = 0;
            else if (ang > FULL_ANGLE)
                ang = FULL_ANGLE;
            cur_angle = ang[fspl_pkg::TGT_W-1:0];
            r.sample_ok = 1'b1;
            if (!seeded) begin
                // First good period after reset only sets the reference angle.
                seeded = 1'b1;
                prev_angle = ang[fspl_pkg::TGT_W-1:0];
            end else begin
                if (ang < QUADRANT_TWO_START * 16 && prev_angle > QUADRANT_THREE_END * 16) begin
                    if (turn_total < 127)
                        turn_total++;
                end else if (prev_angle < QUADRANT_TWO_START * 16 &&
                             ang > QUADRANT_THREE_END * 16) begin
                    if (turn_total > -128)
                        turn_total--;
                end
                prev_angle = ang[fspl_pkg::TGT_W-1:0];

                err = longint'(servo_cfg.target_angle) - ang;
                spd = (err * longint'(servo_cfg.gain_kp)) / 256;
                if (spd > longint'(servo_cfg.max_speed_offset))
                    spd = servo_cfg.max_speed_offset;
                else if (spd < longint'($signed(servo_cfg.min_speed_offset)))
                    spd = $signed(servo_cfg.min_speed_offset);
                if (err > 0)
                    spd = spd + servo_cfg.dead_offset;
                else if (err < 0)
                    spd = spd - servo_cfg.dead_offset;
                // Steer back toward zero net turns.
                if (turn_total >= 1)
                    spd = (spd < 0) ? spd : -spd;
                else if (turn_total < 0)
                    spd = (spd < 0) ? -spd : spd;
                pulse = longint'(servo_cfg.hold_still_us) + spd;
                if (pulse < 0)
                    pulse = 0;
                if (pulse > fspl_pkg::PULSE_MAX)
                    pulse = fspl_pkg::PULSE_MAX;
                last_pulse = pulse[fspl_pkg::PULSE_W-1:0];
            end
        end
        r.pulse_width = last_pulse;
        r.angle_now   = cur_angle;
        r.turn_count  = turn_total;
        return r;
    endfunction

    // Mostly short pauses, now and then a long one, often none at all.
    function automatic int pick_pause();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            return 0;
        else if (roll < 80)
            return $urandom_range(1, 3);
        else if (roll < 95)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Random value in [lo, hi], with the two ends drawn often.
    function automatic int pick_in(int lo, int hi);
        case ($urandom_range(0, 5))
            0: return lo;
            1: return hi;
            default: return lo + int'($urandom_range(0, hi - lo));
        endcase
    endfunction

    // Period whose duty maps to the given angle (whole units) under the
    // current duty settings.
    function automatic fspl_pkg::t_in period_for_angle(int a, int cycle);
        fspl_pkg::t_in p;
        longint        span, hi;
        span = longint'(servo_cfg.duty_high) - longint'(servo_cfg.duty_low) + 1;
        if (span == 0)
            span = 1;
        hi = (longint'(cycle) * (longint'(servo_cfg.duty_low) * UNITS_PER_CIRCLE +
              longint'(UNITS_PER_CIRCLE - 1 - a) * span)) /
             (longint'(UNITS_PER_CIRCLE) * DUTY_FULL_SCALE);
        if (hi < 1)
            hi = 1;
        if (hi > cycle - 1)
            hi = cycle - 1;
        p.high_time = 16'(hi);
        p.low_time  = 16'(cycle - hi);
        return p;
    endfunction

    // One random period. Most walk the shaft through the three angle
    // regions in the given direction so that the turn counter moves; the
    // rest are raw noise, window edges and arbitrary valid periods.
    function automatic fspl_pkg::t_in make_period(int dir);
        fspl_pkg::t_in p;
        int            roll, cycle, a;
        roll = $urandom_range(0, 99);
        cycle = $urandom_range(fspl_pkg::PERIOD_MIN_US + 1, fspl_pkg::PERIOD_MAX_US - 1);
        if (roll < 3) begin
            p.high_time = 16'($urandom_range(0, 65535));
            p.low_time  = 16'($urandom_range(0, 65535));
        end else if (roll < 5) begin
            case ($urandom_range(0, 3))
                0: cycle = fspl_pkg::PERIOD_MIN_US;
                1: cycle = fspl_pkg::PERIOD_MAX_US;
                2: cycle = $urandom_range(0, fspl_pkg::PERIOD_MIN_US);
                default: cycle = $urandom_range(fspl_pkg::PERIOD_MAX_US, 1400);
            endcase
            p.high_time = 16'($urandom_range(0, cycle));
            if ($urandom_range(0, 3) == 0)
                p.high_time = $urandom_range(0, 1) ? 16'(cycle) : '0;
            p.low_time = 16'(cycle - p.high_time);
        end else if (roll < 8) begin
            p.high_time = 16'($urandom_range(1, cycle - 1));
            p.low_time  = 16'(cycle - p.high_time);
        end else begin
            spin_region = (spin_region + ((dir > 0) ? 1 : 2)) % 3;
            case (spin_region)
                0: a = $urandom_range(0, 80);
                1: a = $urandom_range(100, 260);
                default: a = $urandom_range(280, UNITS_PER_CIRCLE - 1);
            endcase
            p = period_for_angle(a, cycle);
        end
        return p;
    endfunction

    // ------------------------------------------------------------------
    // Sender: offer the next pending period at the falling edge, hold it
    // until the transfer completes, then idle for a random gap.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else if (!in_valid || period_taken) begin
            period_taken = 1'b0;
            if (gap_left > 0) begin
                gap_left--;
                in_valid <= 1'b0;
            end else if (pending_periods.size() != 0) begin
                in_data  <= pending_periods.pop_front();
                in_valid <= 1'b1;
                gap_left = pick_pause();
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Receiver: stall for a random stretch after each result. Once, hold
    // off for a long time while the sender keeps going, so the block backs
    // up and stalls its own input.
    // ------------------------------------------------------------------
    always @(negedge clk) begin
        if (result_taken) begin
            result_taken = 1'b0;
            stall_left = pick_pause();
        end
        if (!long_hold_done && results_seen >= 150) begin
            long_hold_done = 1'b1;
            hold_left = 400;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Rising edge: predict each input transfer, check each output transfer
    // against the oldest prediction.
    // ------------------------------------------------------------------
    always @(posedge clk) begin
        fspl_pkg::t_out want;
        fspl_pkg::t_out got;
        if (rst_n && in_valid && !in_stall) begin
            expected_results.push_back(next_feedback_result(in_data));
            period_taken = 1'b1;
        end
        if (rst_n && out_valid && !out_stall) begin
            results_seen++;
            result_taken = 1'b1;
            got = out_data;
            if (expected_results.size() == 0) begin
                $error("result transfer with nothing expected: ok %0d pulse %0d angle %0d",
                       got.sample_ok, got.pulse_width, got.angle_now);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                if (got.sample_ok !== want.sample_ok) begin
                    $error("sample_ok: expected %0d, got %0d", want.sample_ok, got.sample_ok);
                    mismatches++;
                end
                if (got.pulse_width !== want.pulse_width) begin
                    $error("pulse_width: expected %0d, got %0d",
                           want.pulse_width, got.pulse_width);
                    mismatches++;
                end
                if (got.angle_now !== want.angle_now) begin
                    $error("angle_now: expected %0d, got %0d", want.angle_now, got.angle_now);
                    mismatches++;
                end
                if (got.turn_count !== want.turn_count) begin
                    $error("turn_count: expected %0d, got %0d",
                           want.turn_count, got.turn_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog: end a hung run.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge clk);
            cycle_count++;
        end
        $display("TB_ERROR");
        $finish;
    end

    // Write one register and mirror it in the shadow settings.
    task automatic write_cfg_reg(fspl_pkg::t_reg_idx idx, int value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value[fspl_pkg::CFG_W-1:0];
        case (idx)
            fspl_pkg::REG_TARGET_ANGLE:
                servo_cfg.target_angle     = value[fspl_pkg::TGT_W-1:0];
            fspl_pkg::REG_GAIN_KP:
                servo_cfg.gain_kp          = value[fspl_pkg::GAIN_W-1:0];
            fspl_pkg::REG_MAX_SPEED:
                servo_cfg.max_speed_offset = value[fspl_pkg::MAXO_W-1:0];
            fspl_pkg::REG_MIN_SPEED:
                servo_cfg.min_speed_offset = value[fspl_pkg::MINO_W-1:0];
            fspl_pkg::REG_DEAD_OFFSET:
                servo_cfg.dead_offset      = value[fspl_pkg::DEAD_W-1:0];
            fspl_pkg::REG_HOLD_STILL:
                servo_cfg.hold_still_us    = value[fspl_pkg::PULSE_W-1:0];
            fspl_pkg::REG_DUTY_LOW:
                servo_cfg.duty_low         = value[fspl_pkg::DUTY_W-1:0];
            fspl_pkg::REG_DUTY_HIGH:
                servo_cfg.duty_high        = value[fspl_pkg::DUTY_W-1:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_settings(int tgt, int gain, int top, int bottom, int dead,
                                 int hold, int dl, int dh);
        write_cfg_reg(fspl_pkg::REG_TARGET_ANGLE, tgt);
        write_cfg_reg(fspl_pkg::REG_GAIN_KP, gain);
        write_cfg_reg(fspl_pkg::REG_MAX_SPEED, top);
        write_cfg_reg(fspl_pkg::REG_MIN_SPEED, bottom);
        write_cfg_reg(fspl_pkg::REG_DEAD_OFFSET, dead);
        write_cfg_reg(fspl_pkg::REG_HOLD_STILL, hold);
        write_cfg_reg(fspl_pkg::REG_DUTY_LOW, dl);
        write_cfg_reg(fspl_pkg::REG_DUTY_HIGH, dh);
    endtask

    // Wait until every period has been sent and every prediction matched, then let
    // the block settle so that register writes find it idle.
    task automatic wait_until_idle();
        while (pending_periods.size() != 0 || in_valid || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus sequence.
    // ------------------------------------------------------------------
    initial begin
        int  set_no, dir, dl, dh, settle_sets;
        bit  reached_low, reached_high;
        reached_low = 1'b0;
        reached_high = 1'b0;
        settle_sets = 0;

        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, at reset settings. Rejects come first so that the
        // held reset state shows, then the seeding sample, then crossings.
        pending_periods.push_back('{16'd0, 16'd1100});       // high part missing
        pending_periods.push_back('{16'd1100, 16'd0});       // low part missing
        pending_periods.push_back('{16'd0, 16'd0});          // feedback timeout
        pending_periods.push_back('{16'd500, 16'd500});      // period on lower bound
        pending_periods.push_back('{16'd600, 16'd600});      // period on upper bound
        pending_periods.push_back('{16'hFFFF, 16'hFFFF});
        pending_periods.push_back('{16'hFFFF, 16'd1002});    // would fold into window mod 2^16; the wide sum rejects it
        pending_periods.push_back('{16'd1, 16'd1000});       // seeds, angle clipped high
        pending_periods.push_back('{16'd1198, 16'd1});       // clipped to zero, one turn up
        pending_periods.push_back(period_for_angle(180, 1100));
        pending_periods.push_back(period_for_angle(350, 1100));
        pending_periods.push_back(period_for_angle(10, 1100));
        pending_periods.push_back(period_for_angle(350, 1100));
        pending_periods.push_back(period_for_angle(10, 1100));
        pending_periods.push_back(period_for_angle(350, 1100));
        pending_periods.push_back(period_for_angle(180, 1100));
        pending_periods.push_back(period_for_angle(10, 1100));
        pending_periods.push_back(period_for_angle(350, 1100));
        pending_periods.push_back(period_for_angle(180, 1100));
        pending_periods.push_back(period_for_angle(10, 1100));
        pending_periods.push_back(period_for_angle(350, 1100)); // turns go negative
        pending_periods.push_back('{16'd1100, 16'h8000});
        pending_periods.push_back('{16'h8000, 16'd100});
        wait_until_idle();

        // Random sets, each under fresh settings. Spin backward until the
        // turn counter pins at its floor, then forward toward its ceiling;
        // once that pins too, one last set runs in a random direction.
        for (set_no = 0; set_no < MAX_SETS && settle_sets < 1; set_no++) begin
            if (set_no == 0) begin
                load_settings(FULL_ANGLE, 255, 1023, -1023, 255, fspl_pkg::PULSE_MAX,
                              0, DUTY_REG_MAX);
            end else if (set_no == 1) begin
                load_settings(0, 0, 0, 0, 0, 0, DUTY_REG_MAX, 0);
            end else begin
                if ($urandom_range(0, 3) == 0) begin
                    dl = pick_in(0, DUTY_REG_MAX);
                    dh = pick_in(0, DUTY_REG_MAX);
                end else begin
                    dl = pick_in(0, 80);
                    dh = pick_in(920, DUTY_REG_MAX);
                end
                // Duty span of zero: the block falls back to a span of one.
                if (set_no == 2) begin
                    dl = 500;
                    dh = 499;
                end
                load_settings(pick_in(0, FULL_ANGLE), pick_in(0, 255), pick_in(0, 1023),
                              pick_in(-1023, 0), pick_in(0, 255),
                              pick_in(0, fspl_pkg::PULSE_MAX), dl, dh);
            end

            if (!reached_low)
                dir = -1;
            else if (!reached_high)
                dir = 1;
            else begin
                dir = $urandom_range(0, 1) ? 1 : -1;
                settle_sets++;
            end
            repeat (ITEMS_PER_SET) pending_periods.push_back(make_period(dir));
            wait_until_idle();

            if (turn_total == -128)
                reached_low = 1'b1;
            if (reached_low && turn_total == 127)
                reached_high = 1'b1;
        end

        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
